// ----- src/device_reply_sniffer_unit_assert.svh -----
// Assertion macros shared by the device reply sniffer RTL.
`ifndef DEVICE_REPLY_SNIFFER_UNIT_ASSERT_SVH
`define DEVICE_REPLY_SNIFFER_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define DRS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define DRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/drs_pkg.sv -----
// Package with codes, limits and the reply length table of the device reply sniffer.
package drs_pkg;

	localparam int DefMaxCols  = 16;
	localparam int DefMaxRows  = 16;
	localparam int DefMaxRings = 4;

	localparam int STORE_W = 8;
	localparam int LEN_W   = 6;

	localparam logic [1:0] ACT_BYTE     = 2'd0;
	localparam logic [1:0] ACT_RESTART  = 2'd1;
	localparam logic [1:0] ACT_SET_MODE = 2'd2;

	localparam logic [2:0] KIND_NONE  = 3'd0;
	localparam logic [2:0] KIND_SIZE  = 3'd1;
	localparam logic [2:0] KIND_QUERY = 3'd2;
	localparam logic [2:0] KIND_OTHER = 3'd3;
	localparam logic [2:0] KIND_SKIP  = 3'd4;

	localparam logic [7:0] HDR_SIZE_REPLY  = 8'h03;
	localparam logic [7:0] HDR_QUERY_REPLY = 8'h00;
	localparam logic [7:0] SUB_RING        = 8'h05;
	localparam logic [LEN_W-1:0] LEN_SHORT_REPLY = 6'd3;
	localparam logic [LEN_W-1:0] CNT_MAX         = 6'd63;

	localparam logic [STORE_W-1:0] COLS_RESET = 8'd16;
	localparam logic [STORE_W-1:0] ROWS_RESET = 8'd8;

	function automatic logic [LEN_W-1:0] reply_length(input logic [7:0] hdr);
		logic [LEN_W-1:0] len;
		len = 6'd1;
		case (hdr[7:4])
			4'h0: begin
				case (hdr[3:0])
					4'h0: len = 6'd3;
					4'h1: len = 6'd33;
					4'h2: len = 6'd4;
					4'h3, 4'h4: len = 6'd3;
					4'hF: len = 6'd9;
					default: len = 6'd1;
				endcase
			end
			4'h2: len = (hdr[3:0] inside {4'h0, 4'h1}) ? 6'd3 : 6'd1;
			4'h5: begin
				case (hdr[3:0])
					4'h0: len = 6'd3;
					4'h1, 4'h2: len = 6'd2;
					default: len = 6'd1;
				endcase
			end
			4'h8: begin
				case (hdr[3:0])
					4'h0: len = 6'd2;
					4'h1: len = 6'd8;
					default: len = 6'd1;
				endcase
			end
			default: len = 6'd1;
		endcase
		return len;
	endfunction

endpackage

// ----- src/drs_if.sv -----
// Handshake channel interfaces for device reply sniffer transactions.
interface drs_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface drs_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] grid_cols;
	logic [4:0] grid_rows;
	logic [2:0] ring_total;
	logic       ring_mode;
	logic       message_done;
	logic [2:0] message_kind;

	modport source (output valid, output grid_cols, output grid_rows, output ring_total,
		output ring_mode, output message_done, output message_kind, input ready);
	modport sink (input valid, input grid_cols, input grid_rows, input ring_total,
		input ring_mode, input message_done, input message_kind, output ready);
endinterface

// ----- src/device_reply_sniffer_unit.sv -----
// Device reply sniffer: frames device reply bytes and tracks grid size and ring mode.
// One transaction on rx gives exactly one transaction on rsp. Each accepted item is
// fully handled on acceptance: the framer state, the discovered counts and the output
// register all update at the accepting edge, and the result is offered on rsp from the
// next cycle, so the block sustains one item per clock. The only limit is the output
// register: rx stalls only while a result waits there and rsp is not ready. Action 0
// feeds one reply byte, action 1 restarts discovery, action 2 forces ring mode from
// data_byte bit 0 and clears the ring count when that bit is 0.
module device_reply_sniffer_unit
	import drs_pkg::*;
#(
	parameter int MAX_COLS  = DefMaxCols,
	parameter int MAX_ROWS  = DefMaxRows,
	parameter int MAX_RINGS = DefMaxRings
) (
	input  logic         clk,
	input  logic         arst_n,
	drs_in_if.sink       rx,
	drs_out_if.source    rsp
);
	`include "device_reply_sniffer_unit_assert.svh"

	localparam logic [STORE_W-1:0] LimCols  = STORE_W'(MAX_COLS);
	localparam logic [STORE_W-1:0] LimRows  = STORE_W'(MAX_ROWS);
	localparam logic [STORE_W-1:0] LimRings = STORE_W'(MAX_RINGS);

	logic [LEN_W-1:0]   exp_len_q, exp_len_n;
	logic [LEN_W-1:0]   rcv_cnt_q, rcv_cnt_n, cnt_inc;
	logic [7:0]         hdr_q, hdr_n;
	logic [7:0]         pay1_q, pay1_n;
	logic [7:0]         pay2_q, pay2_n;
	logic [STORE_W-1:0] cols_q, cols_n;
	logic [STORE_W-1:0] rows_q, rows_n;
	logic [STORE_W-1:0] rings_q, rings_n;
	logic               mode_q, mode_n;
	logic [LEN_W-1:0]   hdr_len;
	logic               done;
	logic [2:0]         kind;
	logic               accept;

	logic               rsp_valid_q;
	logic [4:0]         cols_out_q, rows_out_q;
	logic [2:0]         rings_out_q, kind_out_q;
	logic               mode_out_q, done_out_q;

	assign rx.ready = !rsp_valid_q || rsp.ready;
	assign accept   = rx.valid && rx.ready;
	assign hdr_len  = reply_length(rx.data_byte);
	assign cnt_inc  = (rcv_cnt_q < CNT_MAX) ? rcv_cnt_q + 6'd1 : rcv_cnt_q;

	always_comb begin
		exp_len_n = exp_len_q;
		rcv_cnt_n = rcv_cnt_q;
		hdr_n     = hdr_q;
		pay1_n    = pay1_q;
		pay2_n    = pay2_q;
		cols_n    = cols_q;
		rows_n    = rows_q;
		rings_n   = rings_q;
		mode_n    = mode_q;
		done      = 1'b0;
		kind      = KIND_NONE;
		case (rx.action)
			ACT_BYTE: begin
				if (exp_len_q == '0) begin
					hdr_n = rx.data_byte;
					if (hdr_len <= 6'd1) begin
						exp_len_n = '0;
						rcv_cnt_n = '0;
						kind      = KIND_SKIP;
					end else begin
						exp_len_n = hdr_len;
						rcv_cnt_n = 6'd1;
					end
				end else begin
					if (rcv_cnt_q == 6'd1) begin
						pay1_n = rx.data_byte;
					end else if (rcv_cnt_q == 6'd2) begin
						pay2_n = rx.data_byte;
					end
					rcv_cnt_n = cnt_inc;
					if (cnt_inc >= exp_len_q) begin
						done      = 1'b1;
						exp_len_n = '0;
						rcv_cnt_n = '0;
						if (hdr_q == HDR_SIZE_REPLY && exp_len_q == LEN_SHORT_REPLY) begin
							kind = KIND_SIZE;
							if (pay1_n != '0 && pay1_n <= LimCols) begin
								cols_n = pay1_n;
							end
							if (pay2_n != '0 && pay2_n <= LimRows) begin
								rows_n = pay2_n;
							end
						end else if (hdr_q == HDR_QUERY_REPLY && exp_len_q == LEN_SHORT_REPLY) begin
							kind = KIND_QUERY;
							if (pay1_n == SUB_RING) begin
								rings_n = (pay2_n > LimRings) ? LimRings : pay2_n;
								if (rings_n != '0) begin
									mode_n = 1'b1;
								end
							end
						end else begin
							kind = KIND_OTHER;
						end
					end
				end
			end
			ACT_RESTART: begin
				cols_n    = '0;
				rows_n    = '0;
				rings_n   = '0;
				mode_n    = 1'b0;
				exp_len_n = '0;
				rcv_cnt_n = '0;
			end
			ACT_SET_MODE: begin
				mode_n = rx.data_byte[0];
				if (!rx.data_byte[0]) begin
					rings_n = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= '0;
			rcv_cnt_q <= '0;
			hdr_q     <= '0;
			pay1_q    <= '0;
			pay2_q    <= '0;
			cols_q    <= COLS_RESET;
			rows_q    <= ROWS_RESET;
			rings_q   <= '0;
			mode_q    <= 1'b0;
		end else if (accept) begin
			exp_len_q <= exp_len_n;
			rcv_cnt_q <= rcv_cnt_n;
			hdr_q     <= hdr_n;
			pay1_q    <= pay1_n;
			pay2_q    <= pay2_n;
			cols_q    <= cols_n;
			rows_q    <= rows_n;
			rings_q   <= rings_n;
			mode_q    <= mode_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cols_out_q  <= cols_n[4:0];
			rows_out_q  <= rows_n[4:0];
			rings_out_q <= rings_n[2:0];
			mode_out_q  <= mode_n;
			done_out_q  <= done;
			kind_out_q  <= kind;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.grid_cols    = cols_out_q;
	assign rsp.grid_rows    = rows_out_q;
	assign rsp.ring_total   = rings_out_q;
	assign rsp.ring_mode    = mode_out_q;
	assign rsp.message_done = done_out_q;
	assign rsp.message_kind = kind_out_q;

	`DRS_ASSERT_NEXT(a_accept_gives_result, clk, arst_n, accept, rsp.valid,
		"accepted transaction gave no result")
	`DRS_ASSERT_SAME(a_done_kind, clk, arst_n, rsp.valid,
		rsp.message_done == (rsp.message_kind == KIND_SIZE ||
		rsp.message_kind == KIND_QUERY || rsp.message_kind == KIND_OTHER),
		"message_done disagrees with message_kind")
	`DRS_ASSERT_SAME(a_rings_need_mode, clk, arst_n, !mode_q, rings_q == '0,
		"ring count set while ring mode is off")
	`DRS_ASSERT_SAME(a_framer_count, clk, arst_n, exp_len_q != '0,
		rcv_cnt_q != '0 && rcv_cnt_q < exp_len_q,
		"framer count out of range for the open message")

endmodule
